// ===== rtl/bchd_pkg.sv =====
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and constants for the button click and hold detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bchd_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_W             = 32;
    localparam int DEBOUNCE_W        = 16;
    localparam int HOLD_W            = 32;
    localparam int COUNT_W           = 16;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_INDEX_W       = 1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [HOLD_W-1:0]     HOLD_RESET     = 32'd1500;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD     = 1'd1;

    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_HOLD  = 1'b1;

    typedef struct packed {
        logic             pin_level;
        logic [NOW_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic               gesture_valid;
        logic               gesture_kind;
        logic               raw_edge;
        logic               raw_edge_is_press;
        logic               stable_pressed;
        logic [COUNT_W-1:0] single_count;
        logic [COUNT_W-1:0] hold_count;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/bchd_core.sv =====
// ----------------------------------------------------------------------------
// bchd_core
// Per-sample debounce, click and hold decision with key state and a
// registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module bchd_core #(
    parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEFAULT
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  bchd_pkg::t_in_item                   i_item,
    input  wire [bchd_pkg::DEBOUNCE_W-1:0]       i_debounce_ticks,
    input  wire [bchd_pkg::HOLD_W-1:0]           i_hold_ticks,
    output bchd_pkg::t_out_item                  o_res
);

    localparam int CMP_W = (TIME_BITS > bchd_pkg::HOLD_W) ? TIME_BITS : bchd_pkg::HOLD_W;

    logic                         r_stable;
    logic                         r_raw;
    logic [TIME_BITS-1:0]         r_press;
    logic [TIME_BITS-1:0]         r_release;
    logic                         r_half;
    logic [bchd_pkg::COUNT_W-1:0] r_single_total;
    logic [bchd_pkg::COUNT_W-1:0] r_hold_total;
    bchd_pkg::t_out_item          r_res;

    logic                         n_stable;
    logic                         n_raw;
    logic [TIME_BITS-1:0]         n_press;
    logic [TIME_BITS-1:0]         n_release;
    logic                         n_half;
    logic [bchd_pkg::COUNT_W-1:0] n_single_total;
    logic [bchd_pkg::COUNT_W-1:0] n_hold_total;
    bchd_pkg::t_out_item          n_res;

    logic                         pressed;
    logic                         edge_seen;
    logic [TIME_BITS-1:0]         now_t;
    logic [TIME_BITS-1:0]         d_held_now;
    logic [TIME_BITS-1:0]         d_since_rel;
    logic [TIME_BITS-1:0]         d_held_rel;
    logic [CMP_W-1:0]             held_now;
    logic [CMP_W-1:0]             since_rel;
    logic [CMP_W-1:0]             held_rel;
    logic [CMP_W-1:0]             deb_w;
    logic [CMP_W-1:0]             hold_w;
    logic                         hold_ev;
    logic                         click_ev;

    assign pressed   = ~i_item.pin_level;
    assign edge_seen = pressed != r_raw;
    assign now_t     = TIME_BITS'(i_item.now);
    assign n_raw     = pressed;
    assign n_press   = (edge_seen && pressed)  ? now_t : r_press;
    assign n_release = (edge_seen && !pressed) ? now_t : r_release;

    // time differences wrap at the time width
    assign d_held_now  = now_t - n_press;
    assign d_since_rel = now_t - n_release;
    assign d_held_rel  = n_release - n_press;

    assign held_now  = CMP_W'(d_held_now);
    assign since_rel = CMP_W'(d_since_rel);
    assign held_rel  = CMP_W'(d_held_rel);
    assign deb_w     = CMP_W'(i_debounce_ticks);
    assign hold_w    = CMP_W'(i_hold_ticks);

    always_comb begin
        n_stable = r_stable;
        n_half   = r_half;
        hold_ev  = 1'b0;
        click_ev = 1'b0;
        if (pressed) begin
            if (!r_stable && (held_now >= deb_w)) begin
                if (held_now >= hold_w) begin
                    n_stable = 1'b1;
                    n_half   = 1'b0;
                    hold_ev  = 1'b1;
                end else begin
                    n_half = 1'b1;
                end
            end
        end else if (since_rel >= deb_w) begin
            if (r_half && (held_rel < hold_w)) begin
                n_half   = 1'b0;
                click_ev = 1'b1;
            end else begin
                n_stable = 1'b0;
                n_half   = 1'b0;
            end
        end
    end

    assign n_single_total = r_single_total + bchd_pkg::COUNT_W'(click_ev);
    assign n_hold_total   = r_hold_total + bchd_pkg::COUNT_W'(hold_ev);

    always_comb begin
        n_res.gesture_valid     = hold_ev | click_ev;
        n_res.gesture_kind      = hold_ev ? bchd_pkg::KIND_HOLD : bchd_pkg::KIND_CLICK;
        n_res.raw_edge          = edge_seen;
        n_res.raw_edge_is_press = edge_seen & pressed;
        n_res.stable_pressed    = n_stable;
        n_res.single_count      = n_single_total;
        n_res.hold_count        = n_hold_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable       <= 1'b0;
            r_raw          <= 1'b0;
            r_press        <= '0;
            r_release      <= '0;
            r_half         <= 1'b0;
            r_single_total <= '0;
            r_hold_total   <= '0;
            r_res          <= '0;
        end else if (i_en) begin
            r_stable       <= n_stable;
            r_raw          <= n_raw;
            r_press        <= n_press;
            r_release      <= n_release;
            r_half         <= n_half;
            r_single_total <= n_single_total;
            r_hold_total   <= n_hold_total;
            r_res          <= n_res;
        end
    end

    assign o_res = r_res;

    // hold report leaves the key stable pressed
    a_hold_sets_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && hold_ev) |=> (r_stable && r_res.stable_pressed && !r_half))
        else $error("hold report did not set stable state");

    // counters only move on their own event
    a_hold_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !hold_ev) |=> (r_hold_total == $past(r_hold_total)))
        else $error("hold count moved without a hold");

    a_single_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && click_ev) |=>
            (r_single_total == bchd_pkg::COUNT_W'($past(r_single_total) + 1'b1)) && !r_half)
        else $error("single click not counted");

    // no events on a pressed and a released sample at once
    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hold_ev && click_ev))
        else $error("click and hold in the same sample");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_res) && $stable(r_stable) && $stable(r_half)))
        else $error("state changed without an item");

endmodule

`default_nettype wire

// ===== rtl/button_click_hold_detector.sv =====
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Debounced click and press-and-hold detection on an active-low key pin.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input item is held in the input register, then the
//   decision logic writes the result register; an output stall holds both.
// Throughput: one item per cycle when not stalled, one result per input item.
// Reset: synchronous active low; key taken as released, stamps and counters
//   zero, debounce_ticks 50, hold_ticks 1500, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_hold_detector #(
    parameter int TIME_BITS = bchd_pkg::TIME_BITS_DEFAULT
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  bchd_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output bchd_pkg::t_out_item                   o_out_item,
    input  wire                                   i_cfg_we,
    input  wire [bchd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire [bchd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    logic [bchd_pkg::DEBOUNCE_W-1:0] r_debounce_ticks;
    logic [bchd_pkg::HOLD_W-1:0]     r_hold_ticks;
    logic                            r_s1_valid;
    bchd_pkg::t_in_item              r_s1_item;
    logic                            r_out_valid;
    logic                            adv;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= bchd_pkg::DEBOUNCE_RESET;
            r_hold_ticks     <= bchd_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bchd_pkg::CFG_DEBOUNCE: begin
                    r_debounce_ticks <= i_cfg_wdata[bchd_pkg::DEBOUNCE_W-1:0];
                end
                bchd_pkg::CFG_HOLD: begin
                    r_hold_ticks <= i_cfg_wdata[bchd_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item <= i_in_item;
        end
    end

    bchd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (r_s1_valid && adv),
        .i_item           (r_s1_item),
        .i_debounce_ticks (r_debounce_ticks),
        .i_hold_ticks     (r_hold_ticks),
        .o_res            (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
